// ----- rtl/gomt_pkg.sv -----
// Shared types, constants and helper functions of the greedy overlap merge tracker.
// Used by gomt_free_map and greedy_overlap_merge_tracker; depends on nothing.

package gomt_pkg;

  // Sizes of the string index space and the availability bitmap.
  localparam int MAX_STRINGS = 1024;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int WORD_W      = 32;
  localparam int POS_W       = 5;
  localparam int WORDS       = MAX_STRINGS / WORD_W;
  localparam int WADDR_W     = IDX_W - POS_W;

  // Field widths of the input and result beats.
  localparam int OLEN_W   = 16;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 40;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MERGED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd2;

  // Request to mark one string as no longer available on the right side.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } free_wr_t;

  // Position of the lowest set bit of a word; zero when the word is empty.
  function automatic logic [POS_W-1:0] first_set(input logic [WORD_W-1:0] word);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (word[i]) pos = POS_W'(i);
    end
    return pos;
  endfunction

endpackage

// ----- rtl/gomt_free_map.sv -----
// Right-availability bitmap of the merge tracker, kept as 32-bit words.
// Depends on gomt_pkg for sizes and the write request struct.

module gomt_free_map (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [gomt_pkg::WADDR_W-1:0]    rd_word,
  output logic [gomt_pkg::WORD_W-1:0]     rd_data,
  input  gomt_pkg::free_wr_t              wr
);

  logic [gomt_pkg::WORD_W-1:0] map [gomt_pkg::WORDS];

  // Reset marks every string free; a merge clears the bit of its right string.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gomt_pkg::WORDS; i++) begin
        map[i] <= '1;
      end
    end else if (wr.en) begin
      map[wr.idx[gomt_pkg::IDX_W-1:gomt_pkg::POS_W]][wr.idx[gomt_pkg::POS_W-1:0]] <= 1'b0;
    end
  end

  // One word is read per cycle at the address the sequencer chooses.
  assign rd_data = map[rd_word];

endmodule

// ----- rtl/greedy_overlap_merge_tracker.sv -----
// Top level of the greedy overlap merge tracker: sequencer, left-end memory, result register.
// Depends on gomt_pkg and instantiates gomt_free_map.

// Each input beat offers one overlap candidate and yields exactly one result beat.
// The block takes a beat only when idle and then works on it alone. A beat that is
// rejected at once (all merges done, bad rank) goes straight to the response state.
// Otherwise the sequencer scans the availability bitmap one 32-bit word per cycle,
// from the word holding interval_begin up to the word holding the clamped interval
// end. When the candidate found is the left string itself, it rescans the same word
// above that string. A result that waits on the output holds the block in its
// response state; the next beat can be taken at the edge after the result is loaded.
// No clearing pass is needed after reset: a left-end entry is valid exactly when its
// string has been merged, so the availability bit selects between the memory and
// the index.

module greedy_overlap_merge_tracker (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration: string_count.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gomt_pkg::CNT_W-1:0]  cfg_data,
  // Input beats.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // read_rank[10:0], overlap_len[26:11], interval_begin[36:27], interval_end[46:37], pad[47]
  input  logic [gomt_pkg::IN_W-1:0]   s_axis_tdata,
  // Result beats.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status[1:0], merge_left[11:2], merge_right[21:12], merge_overlap[37:22], pad[39:38]
  output logic [gomt_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  localparam int IW = gomt_pkg::IDX_W;
  localparam int CW = gomt_pkg::CNT_W;
  localparam int PW = gomt_pkg::POS_W;
  localparam int AW = gomt_pkg::WADDR_W;
  localparam int WW = gomt_pkg::WORD_W;

  logic [1:0]                     state;
  logic [CW-1:0]                  string_count;
  logic [CW-1:0]                  merge_count;
  logic [IW-1:0]                  left;
  logic                           left_free;
  logic [gomt_pkg::OLEN_W-1:0]    olen;
  logic [IW-1:0]                  iend_c;
  logic [AW-1:0]                  w;
  logic [WW-1:0]                  mask;
  logic                           second_try;
  logic [IW-1:0]                  lend_q;
  logic [gomt_pkg::STATUS_W-1:0]  res_status;
  logic [IW-1:0]                  res_right;
  logic [IW-1:0]                  left_end_mem [gomt_pkg::MAX_STRINGS];

  // Output register.
  logic                           out_valid;
  logic [gomt_pkg::STATUS_W-1:0]  out_status;
  logic [IW-1:0]                  out_left;
  logic [IW-1:0]                  out_right;
  logic [gomt_pkg::OLEN_W-1:0]    out_overlap;

  // Unpacked input fields.
  logic [CW-1:0]                  in_rank;
  logic [gomt_pkg::OLEN_W-1:0]    in_olen;
  logic [IW-1:0]                  in_ibeg;
  logic [IW-1:0]                  in_iend;
  logic [IW-1:0]                  in_left;

  logic [CW-1:0]                  cnt_eff;
  logic [CW-1:0]                  cnt_m1;
  logic                           accept;
  logic [AW-1:0]                  rd_word;
  logic [WW-1:0]                  rd_data;
  logic [WW-1:0]                  word;
  logic [PW-1:0]                  pos;
  logic [IW-1:0]                  k;
  logic [IW-1:0]                  lend;
  logic                           merge_do;
  logic                           resp_load;
  gomt_pkg::free_wr_t             free_wr;

  assign in_rank = s_axis_tdata[10:0];
  assign in_olen = s_axis_tdata[26:11];
  assign in_ibeg = s_axis_tdata[36:27];
  assign in_iend = s_axis_tdata[46:37];
  assign in_left = IW'(in_rank - CW'(1));

  // Effective string count: zero acts as one, anything above the maximum is clipped.
  always_comb begin
    if (string_count == '0) begin
      cnt_eff = CW'(1);
    end else if (string_count > CW'(gomt_pkg::MAX_STRINGS)) begin
      cnt_eff = CW'(gomt_pkg::MAX_STRINGS);
    end else begin
      cnt_eff = string_count;
    end
  end
  assign cnt_m1 = cnt_eff - CW'(1);

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // The bitmap port reads the left string's word at accept and the scan word afterwards.
  assign rd_word = (state == S_IDLE) ? in_left[IW-1:PW] : w;

  gomt_free_map u_free_map (
    .clk     (clk),
    .rst     (rst),
    .rd_word (rd_word),
    .rd_data (rd_data),
    .wr      (free_wr)
  );

  // Scan datapath: masked word, its lowest free position and the candidate index.
  assign word = rd_data & mask;
  assign pos  = gomt_pkg::first_set(word);
  assign k    = {w, pos};
  // A free string still has its reset left end, its own index.
  assign lend = left_free ? left : lend_q;

  assign merge_do    = (state == S_SCAN) && (word != '0) && (k <= iend_c) && (k != left);
  assign free_wr.en  = merge_do;
  assign free_wr.idx = k;
  assign resp_load   = (state == S_RESP) && (!out_valid || m_axis_tready);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      string_count <= CW'(gomt_pkg::MAX_STRINGS);
    end else if (cfg_valid) begin
      string_count <= cfg_data;
    end
  end

  // Left-end memory: read for the left string at accept, written on a merge.
  always_ff @(posedge clk) begin
    if (accept) begin
      lend_q <= left_end_mem[in_left];
    end
    if (merge_do) begin
      left_end_mem[k] <= lend;
    end
  end

  // Sequencer and merge counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      merge_count <= '0;
      second_try  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (merge_count >= cnt_m1) begin
              res_status <= gomt_pkg::ST_DONE;
              state      <= S_RESP;
            end else if (in_rank == '0 || in_rank > cnt_eff) begin
              res_status <= gomt_pkg::ST_NONE;
              state      <= S_RESP;
            end else begin
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (word == '0) begin
            if (w >= iend_c[IW-1:PW]) begin
              res_status <= gomt_pkg::ST_NONE;
              state      <= S_RESP;
            end
          end else if (k > iend_c) begin
            res_status <= gomt_pkg::ST_NONE;
            state      <= S_RESP;
          end else if (k == left) begin
            if (second_try) begin
              res_status <= gomt_pkg::ST_NONE;
              state      <= S_RESP;
            end
            second_try <= 1'b1;
          end else begin
            merge_count <= merge_count + CW'(1);
            res_status  <= gomt_pkg::ST_MERGED;
            state       <= S_RESP;
          end
        end
        S_RESP: begin
          if (resp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (accept) begin
        second_try <= 1'b0;
      end
    end
  end

  // Per-item working registers; they need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      left      <= in_left;
      left_free <= rd_data[in_left[PW-1:0]];
      olen      <= in_olen;
      iend_c    <= (in_iend > cnt_m1[IW-1:0]) ? cnt_m1[IW-1:0] : in_iend;
      w         <= in_ibeg[IW-1:PW];
      mask      <= {WW{1'b1}} << in_ibeg[PW-1:0];
    end else if (state == S_SCAN) begin
      if (word == '0) begin
        if (w < iend_c[IW-1:PW]) begin
          w    <= w + AW'(1);
          mask <= '1;
        end
      end else if (k == left) begin
        // Second try continues above the rejected candidate.
        mask <= {WW{1'b1}} << ({1'b0, pos} + (PW + 1)'(1));
      end
    end
    if (merge_do) begin
      res_right <= k;
    end
  end

  // Output register; unused fields read zero unless a merge is reported.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_status <= res_status;
      if (res_status == gomt_pkg::ST_MERGED) begin
        out_left    <= left;
        out_right   <= res_right;
        out_overlap <= olen;
      end else begin
        out_left    <= '0;
        out_right   <= '0;
        out_overlap <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_overlap, out_right, out_left, out_status};

  // A merge bumps the counter by one and the new result waits in the response state.
  a_merge_count: assert property (@(posedge clk) disable iff (rst)
    merge_do |=> (merge_count == $past(merge_count) + CW'(1)) && (state == S_RESP))
    else $error("merge counter did not advance on a merge");

  // A reported merge never joins a string to itself.
  a_merge_distinct: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_status == gomt_pkg::ST_MERGED) |-> (out_left != out_right))
    else $error("merge reported with equal left and right strings");

  // The block is busy in the cycle after it takes a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

endmodule
